// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crq_pkg.sv =====
// Types and constants shared by the circular queue modules.
`timescale 1ns / 1ps
`default_nettype none

package crq_pkg;

  localparam int unsigned CAP_W   = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TDATA_W = 40;

  localparam logic [CAP_W-1:0]  CAP_RESET      = 7'd64;
  localparam logic [DATA_W-1:0] UNDERFLOW_DATA = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REV = 2'd2,
    OP_NOP = 2'd3
  } crq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_INVALID   = 2'd3
  } crq_status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FOLD,
    BK_DEQ,
    BK_REV_MOD,
    BK_SWAP_RD,
    BK_SWAP_WA,
    BK_SWAP_WB,
    BK_REV_END
  } crq_state_e;

  typedef struct packed {
    crq_op_e           op;
    logic [DATA_W-1:0] value;
    logic [CAP_W-1:0]  k;
  } crq_req_t;

endpackage

`default_nettype wire

// ===== hdl/circular_queue_reverse_first_k_core.sv =====
// A request passes through the two-entry front queue to the executor; results are registered.
// Enqueue, overflow, underflow, invalid and unknown requests are finished in the idle state.
// Dequeue reads through a registered memory read port and answers from the BK_DEQ state.
// Reverse reduces the span end by capacity subtractions, then swaps floor(k/2) pairs.
// Each capacity write starts a fold pass that delays work.
// Reset is asynchronous active low: queue empty, capacity 64, memory contents kept.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_reverse_first_k_core
  import crq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CAP_W-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // value [31:0], k [38:32]
  input  wire logic [1:0]         s_axis_tuser,  // req_type [1:0]
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [TDATA_W-1:0] m_axis_tdata,  // data [31:0], occupancy [38:32]
  output      logic [1:0]         m_axis_tuser   // status [1:0]
);

  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'((DEPTH > 127) ? 127 : DEPTH);

  logic [CAP_W-1:0] cap_q;
  logic [CAP_W-1:0] eff_cap;
  logic             req_valid, req_ready;
  crq_req_t         req;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp the capacity into 1..min(DEPTH, 127).
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = 7'd1;
    end else if (cap_q > CAP_LIMIT) begin
      eff_cap = CAP_LIMIT;
    end else begin
      eff_cap = cap_q;
    end
  end

  crq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  crq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_cap_i     (eff_cap),
    .cap_wr_i      (cfg_we_i),
    .req_valid_i   (req_valid),
    .req_ready_o   (req_ready),
    .req_i         (req),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/crq_front.sv =====
// Front end: accepts request transfers, decodes them and buffers them in a short queue.
`timescale 1ns / 1ps
`default_nettype none

module crq_front
  import crq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // value [31:0], k [38:32]
  input  wire logic [1:0]         s_axis_tuser,  // req_type [1:0]
  output      logic               req_valid_o,
  input  wire logic               req_ready_i,
  output      crq_req_t           req_o
);

  crq_req_t   slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  crq_req_t   dec_req;
  logic       push, pop;

  // Decode the request kind and split the data word.
  always_comb begin
    dec_req.value = s_axis_tdata[DATA_W-1:0];
    dec_req.k     = s_axis_tdata[DATA_W+CAP_W-1:DATA_W];
    unique case (s_axis_tuser)
      2'd0:    dec_req.op = OP_ENQ;
      2'd1:    dec_req.op = OP_DEQ;
      2'd2:    dec_req.op = OP_REV;
      default: dec_req.op = OP_NOP;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (cnt_q != 2'd0);
  assign pop           = req_valid_o && req_ready_i;
  assign req_o         = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec_req;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crq_back.sv =====
// Back end: executes queued requests on the word memory and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module crq_back
  import crq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [CAP_W-1:0]   eff_cap_i,
  input  wire logic               cap_wr_i,
  input  wire logic               req_valid_i,
  output      logic               req_ready_o,
  input  wire crq_req_t           req_i,
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [TDATA_W-1:0] m_axis_tdata,  // data [31:0], occupancy [38:32]
  output      logic [1:0]         m_axis_tuser   // status [1:0]
);

  // Indexes never reach 128 because the capacity register is 7 bits wide.
  localparam int unsigned MD = (DEPTH < 128) ? DEPTH : 128;
  localparam int unsigned AW = $clog2(MD);

  crq_state_e        state_q, state_d;
  logic [CAP_W-1:0]  head_q, head_d, tail_q, tail_d, fill_q, fill_d;
  logic [CAP_W-1:0]  head_mod_q, head_mod_d, tail_mod_q, tail_mod_d;
  logic [CAP_W-1:0]  a_q, a_d;
  logic [CAP_W:0]    b_q, b_d;
  logic [CAP_W-2:0]  cnt_q, cnt_d;
  logic              fold_pend_q, fold_pend_d;

  logic [DATA_W-1:0] mem_q [MD];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] mem_wdata, rdata_a_q, rdata_b_q;
  logic              rd_en;

  logic              out_valid_q;
  crq_status_e       out_status_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CAP_W-1:0]  out_occ_q;
  logic              out_free;
  logic              emit;
  crq_status_e       emit_status;
  logic [DATA_W-1:0] emit_data;
  logic [CAP_W-1:0]  emit_occ;

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer: one request at a time, swaps take a read and two writes.
  // head_q and tail_q keep the stored indexes; the _mod copies hold them
  // reduced modulo the current capacity and are the ones used for access.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    head_mod_d  = head_mod_q;
    tail_mod_d  = tail_mod_q;
    a_d         = a_q;
    b_d         = b_q;
    cnt_d       = cnt_q;
    fold_pend_d = fold_pend_q;
    req_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(tail_mod_q);
    mem_wdata   = req_i.value;
    rd_en       = 1'b0;
    raddr_a     = AW'(a_q);
    raddr_b     = AW'(b_q);
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_data   = '0;
    emit_occ    = fill_q;

    unique case (state_q)
      BK_IDLE: begin
        raddr_a = AW'(head_mod_q);
        if (fold_pend_q) begin
          // Restart the reduction from the stored indexes.
          head_mod_d  = head_q;
          tail_mod_d  = tail_q;
          fold_pend_d = 1'b0;
          state_d     = BK_FOLD;
        end else if (req_valid_i && out_free) begin
          req_ready_o = 1'b1;
          unique case (req_i.op)
            OP_ENQ: begin
              emit = 1'b1;
              if (fill_q >= eff_cap_i) begin
                emit_status = ST_OVERFLOW;
              end else begin
                mem_we     = 1'b1;
                tail_d     = (tail_mod_q + 7'd1 == eff_cap_i) ? '0 : tail_mod_q + 7'd1;
                tail_mod_d = tail_d;
                fill_d     = fill_q + 7'd1;
                emit_occ   = fill_d;
              end
            end
            OP_DEQ: begin
              if (fill_q == '0) begin
                emit        = 1'b1;
                emit_status = ST_UNDERFLOW;
                emit_data   = UNDERFLOW_DATA;
              end else begin
                rd_en      = 1'b1;
                head_d     = (head_mod_q + 7'd1 == eff_cap_i) ? '0 : head_mod_q + 7'd1;
                head_mod_d = head_d;
                fill_d     = fill_q - 7'd1;
                state_d    = BK_DEQ;
              end
            end
            OP_REV: begin
              if (req_i.k == '0 || req_i.k > fill_q) begin
                emit        = 1'b1;
                emit_status = ST_INVALID;
              end else begin
                a_d     = head_mod_q;
                b_d     = {1'b0, head_mod_q} + {1'b0, req_i.k} - 8'd1;
                cnt_d   = req_i.k[CAP_W-1:1];
                state_d = BK_REV_MOD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      // Fold the indexes into a changed capacity, one subtraction per cycle.
      BK_FOLD: begin
        if (head_mod_q >= eff_cap_i) begin
          head_mod_d = head_mod_q - eff_cap_i;
        end
        if (tail_mod_q >= eff_cap_i) begin
          tail_mod_d = tail_mod_q - eff_cap_i;
        end
        if (head_mod_q < eff_cap_i && tail_mod_q < eff_cap_i) begin
          state_d = BK_IDLE;
        end
      end

      BK_DEQ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rdata_a_q;
          state_d   = BK_IDLE;
        end
      end

      // Reduce the far end address of the reversed span modulo the capacity.
      BK_REV_MOD: begin
        if (b_q >= {1'b0, eff_cap_i}) begin
          b_d = b_q - {1'b0, eff_cap_i};
        end else if (cnt_q == '0) begin
          state_d = BK_REV_END;
        end else begin
          state_d = BK_SWAP_RD;
        end
      end

      BK_SWAP_RD: begin
        rd_en   = 1'b1;
        state_d = BK_SWAP_WA;
      end

      BK_SWAP_WA: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(a_q);
        mem_wdata = rdata_b_q;
        state_d   = BK_SWAP_WB;
      end

      BK_SWAP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(b_q);
        mem_wdata = rdata_a_q;
        cnt_d     = cnt_q - 6'd1;
        a_d       = (a_q + 7'd1 == eff_cap_i) ? '0 : a_q + 7'd1;
        b_d       = (b_q[CAP_W-1:0] == '0) ? {1'b0, eff_cap_i - 7'd1} : b_q - 8'd1;
        state_d   = (cnt_q == 6'd1) ? BK_REV_END : BK_SWAP_RD;
      end

      BK_REV_END: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // A capacity write always asks for a fold pass.
    if (cap_wr_i) begin
      fold_pend_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      head_mod_q  <= '0;
      tail_mod_q  <= '0;
      a_q         <= '0;
      b_q         <= '0;
      cnt_q       <= '0;
      fold_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      head_mod_q  <= head_mod_d;
      tail_mod_q  <= tail_mod_d;
      a_q         <= a_d;
      b_q         <= b_d;
      cnt_q       <= cnt_d;
      fold_pend_q <= fold_pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= emit_status;
      out_data_q   <= emit_data;
      out_occ_q    <= emit_occ;
    end
  end

  // Word memory: one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_a_q <= mem_q[raddr_a];
      rdata_b_q <= mem_q[raddr_b];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_occ_q, out_data_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== hdl/crq_checker.sv =====
// Port-level checker for the circular queue core and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crq_checker
  import crq_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [TDATA_W-1:0] m_axis_tdata,  // data [31:0], occupancy [38:32]
  input wire logic [1:0]         m_axis_tuser   // status [1:0]
);

  logic               vld;
  logic               stall;
  logic [TDATA_W+1:0] res_w;
  logic [DATA_W-1:0]  dat;
  logic [CAP_W-1:0]   occ;
  logic               unf;
  logic               ovf;
  logic               inv;

  // Short names for the result fields.
  assign vld   = m_axis_tvalid;
  assign stall = m_axis_tvalid && !m_axis_tready;
  assign res_w = {m_axis_tuser, m_axis_tdata};
  assign dat   = m_axis_tdata[DATA_W-1:0];
  assign occ   = m_axis_tdata[DATA_W+CAP_W-1:DATA_W];
  assign unf   = vld && (m_axis_tuser == ST_UNDERFLOW);
  assign ovf   = vld && (m_axis_tuser == ST_OVERFLOW);
  assign inv   = vld && (m_axis_tuser == ST_INVALID);

  // A stalled result keeps its payload.
  `CRQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stall, vld && $stable(res_w), "stalled result changed")

  // An underflow carries all ones and an empty queue.
  `CRQ_ASSERT_IMP(a_underflow, clk_i, rst_ni, unf, dat == UNDERFLOW_DATA && occ == '0, "underflow")

  // An overflow only happens with a non-empty queue and carries zero data.
  `CRQ_ASSERT_IMP(a_overflow, clk_i, rst_ni, ovf, dat == '0 && occ != '0, "bad overflow")

  // An invalid reverse request carries zero data.
  `CRQ_ASSERT_IMP(a_invalid, clk_i, rst_ni, inv, dat == '0, "bad invalid-k result")

endmodule

bind circular_queue_reverse_first_k_core crq_checker u_crq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/circular_queue_reverse_first_k_core_tb.sv =====
// Self-checking testbench for the circular queue core with reverse-first-k requests.
`timescale 1ns / 1ps

module circular_queue_reverse_first_k_core_tb;
  import crq_pkg::*;

  localparam int unsigned QDEPTH         = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned MAX_REPORTS    = 100;

  // One expected response of the queue.
  typedef struct packed {
    crq_status_e       status;
    logic [DATA_W-1:0] data;
    logic [CAP_W-1:0]  occupancy;
  } queue_result_t;

  // Shadow copy of the queue plus the responses still owed by the block.
  class queue_scoreboard;
    logic [DATA_W-1:0] slots [QDEPTH];
    bit                written [QDEPTH];
    int unsigned       head_ptr;
    int unsigned       tail_ptr;
    int unsigned       count;
    int unsigned       cap_reg;
    int unsigned       errors;
    queue_result_t     pending_results [$];

    function new();
      head_ptr = 0;
      tail_ptr = 0;
      count    = 0;
      cap_reg  = 32'(CAP_RESET);
      errors   = 0;
      foreach (slots[i]) begin
        slots[i]   = '0;
        written[i] = 1'b0;
      end
    endfunction

    // Capacity register clamped to the range the storage supports.
    function int unsigned active_cap();
      if (cap_reg < 1) return 1;
      if (cap_reg > QDEPTH) return QDEPTH;
      return cap_reg;
    endfunction

    function void set_capacity(int unsigned cap);
      cap_reg = cap & 7'h7F;
    endfunction

    // A resize with entries held is only safe once every slot holds a written word.
    function bit resize_safe();
      if (count == 0) return 1'b1;
      foreach (written[i]) begin
        if (!written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Apply one accepted request to the shadow queue and queue up its response.
    function void apply_request(crq_op_e op, logic [DATA_W-1:0] value, logic [CAP_W-1:0] k);
      int unsigned   cap;
      int unsigned   kk;
      int unsigned   a;
      int unsigned   b;
      logic [DATA_W-1:0] tmp;
      queue_result_t res;
      cap        = active_cap();
      kk         = 32'(k);
      res.status = ST_OK;
      res.data   = '0;
      case (op)
        OP_ENQ: begin
          if (count >= cap) begin
            res.status = ST_OVERFLOW;
          end else begin
            a          = tail_ptr % cap;
            slots[a]   = value;
            written[a] = 1'b1;
            tail_ptr   = (a + 1) % cap;
            count++;
          end
        end
        OP_DEQ: begin
          if (count == 0) begin
            res.status = ST_UNDERFLOW;
            res.data   = UNDERFLOW_DATA;
          end else begin
            a        = head_ptr % cap;
            res.data = slots[a];
            head_ptr = (a + 1) % cap;
            count--;
          end
        end
        OP_REV: begin
          if (kk == 0 || kk > count) begin
            res.status = ST_INVALID;
          end else begin
            // Swap pairs from the outside in, in the same order as the hardware.
            for (int unsigned i = 0; i < kk / 2; i++) begin
              a        = (head_ptr + i) % cap;
              b        = (head_ptr + kk - 1 - i) % cap;
              tmp      = slots[a];
              slots[a] = slots[b];
              slots[b] = tmp;
            end
          end
        end
        default: begin
        end
      endcase
      res.occupancy = CAP_W'(count);
      pending_results.push_back(res);
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Compare one response transfer against the oldest expectation.
    function void check_result(logic [1:0] status, logic [DATA_W-1:0] data,
                               logic [CAP_W-1:0] occupancy);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
      if (data !== want.data)
        report_mismatch($sformatf("data %h, expected %h", data, want.data));
      if (occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", occupancy, want.occupancy));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CAP_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // value [31:0], k [38:32]
  logic [1:0]         s_axis_tuser;   // req_type [1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // data [31:0], occupancy [38:32]
  logic [1:0]         m_axis_tuser;   // status [1:0]

  queue_scoreboard sb;
  int unsigned     idle_cycles = 0;
  int unsigned     burst_left  = 0;
  bit              filling     = 1'b1;

  circular_queue_reverse_first_k_core #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock with a 20 ns period.
  always #10 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long, with stretches of no idling.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) burst_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Watch both ports: note requests, check responses, and stop on a stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.apply_request(crq_op_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[38:32]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32]);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Response side: ready in runs, with random stalls.
  initial begin : response_sink
    int unsigned hold;
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      hold = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(20, 60);
      repeat (hold) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Send one request; entered and left at a falling edge.
  task automatic send_request(input crq_op_e op, input logic [DATA_W-1:0] value,
                              input logic [CAP_W-1:0] k);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {1'b0, k, value};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every response has arrived.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the capacity register while the block is idle.
  task automatic change_capacity(input int unsigned cap);
    wait_idle();
    if (!sb.resize_safe()) begin
      while (sb.count > 0) send_request(OP_DEQ, $urandom, CAP_W'($urandom));
      wait_idle();
    end
    cfg_wdata_i = CAP_W'(cap);
    cfg_we_i    = 1'b1;
    sb.set_capacity(cap);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random traffic that alternates between filling the queue and draining it.
  task automatic run_random(input int unsigned n);
    crq_op_e           op;
    logic [DATA_W-1:0] value;
    logic [CAP_W-1:0]  k;
    int unsigned       r;
    for (int unsigned i = 0; i < n; i++) begin
      if (sb.count >= sb.active_cap()) filling = 1'b0;
      else if (sb.count == 0) filling = 1'b1;
      case ($urandom_range(7))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      k = CAP_W'($urandom);
      r = $urandom_range(99);
      if (r < 4) begin
        op = OP_NOP;
      end else if (r < 9) begin
        op = OP_REV;
        k  = $urandom_range(1) ? '0 : CAP_W'($urandom_range(sb.count + 1, 127));
      end else if (r < 25) begin
        op = OP_REV;
        if (sb.count == 0) k = CAP_W'($urandom_range(1));
        else if ($urandom_range(3) == 0) k = CAP_W'(sb.count);
        else k = CAP_W'($urandom_range(1, sb.count));
      end else if (filling) begin
        op = (r < 82) ? OP_ENQ : OP_DEQ;
      end else begin
        op = (r < 43) ? OP_ENQ : OP_DEQ;
      end
      send_request(op, value, k);
    end
  endtask

  // Main sequence: reset, directed cases, then random phases at several capacities.
  initial begin : stimulus
    int unsigned cap_plan [$];
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ENQ;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue: underflow, invalid k, unknown request.
    send_request(OP_DEQ, 32'h0000_0000, 7'd0);
    send_request(OP_REV, 32'h0000_0000, 7'd0);
    send_request(OP_REV, 32'h0000_0000, 7'd1);
    send_request(OP_NOP, 32'hFFFF_FFFF, 7'h7F);
    // Extreme words, then reversals of the whole queue and of parts of it.
    send_request(OP_ENQ, 32'h8000_0000, 7'd0);
    send_request(OP_ENQ, 32'h7FFF_FFFF, 7'h7F);
    send_request(OP_ENQ, 32'hFFFF_FFFF, 7'd0);
    send_request(OP_ENQ, 32'h0000_0000, 7'd0);
    send_request(OP_ENQ, 32'h5A5A_A5A5, 7'd0);
    send_request(OP_REV, 32'h0000_0000, 7'd5);
    send_request(OP_REV, 32'h0000_0000, 7'd6);
    send_request(OP_REV, 32'hFFFF_FFFF, 7'h7F);
    send_request(OP_REV, 32'h0000_0000, 7'd0);
    send_request(OP_REV, 32'h0000_0000, 7'd1);
    send_request(OP_REV, 32'h0000_0000, 7'd2);
    send_request(OP_DEQ, 32'hFFFF_FFFF, 7'h7F);
    send_request(OP_DEQ, 32'h0000_0000, 7'd0);
    send_request(OP_NOP, 32'h0000_0000, 7'd0);
    send_request(OP_REV, 32'h0000_0000, 7'd3);
    send_request(OP_DEQ, 32'h0000_0000, 7'd0);
    send_request(OP_DEQ, 32'h0000_0000, 7'd0);
    send_request(OP_DEQ, 32'h0000_0000, 7'd0);
    send_request(OP_DEQ, 32'h0000_0000, 7'd0);

    run_random(130);
    cap_plan = '{1, 0, 127, 5, 64, 2, 100};
    cap_plan.push_back($urandom_range(0, 127));
    foreach (cap_plan[p]) begin
      change_capacity(cap_plan[p]);
      run_random(85);
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) sb.report_mismatch("requests left without a response");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
